// File: hdl/tmh_pkg.sv
package tmh_pkg;

    // default heap size and pop limit per tick
    localparam int HEAP_DEPTH_DEF = 64;
    localparam int MAX_POP        = 64;
    localparam int POP_W          = $clog2(MAX_POP + 1);

    // payload widths
    localparam int REQ_W      = 2;
    localparam int TIME_W     = 48;
    localparam int HANDLE_W   = 32;
    localparam int SESSION_W  = 32;
    localparam int INTERVAL_W = 31;
    localparam int STATUS_W   = 3;

    // request codes
    localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY    = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_REGISTERED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FIRED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NONE       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd5;

    // one heap entry as stored in memory
    typedef struct packed {
        logic [TIME_W-1:0]           expiry;
        logic [HANDLE_W-1:0]         owner;
        logic signed [SESSION_W-1:0] session;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // one result word
    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic [HANDLE_W-1:0]         handle;
        logic signed [SESSION_W-1:0] session;
        logic [TIME_W-1:0]           timeout;
        logic                        last;
    } res_t;

    function automatic res_t make_res(
        input logic [STATUS_W-1:0]         st,
        input logic [HANDLE_W-1:0]         h,
        input logic signed [SESSION_W-1:0] s,
        input logic [TIME_W-1:0]           t,
        input logic                        l
    );
        res_t r;
        r.status  = st;
        r.handle  = h;
        r.session = s;
        r.timeout = t;
        r.last    = l;
        return r;
    endfunction

endpackage

// File: hdl/tmh_if.sv
interface tmh_req_if import tmh_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [REQ_W-1:0]            req_type;
    logic [TIME_W-1:0]           now_ms;
    logic [HANDLE_W-1:0]         owner_handle;
    logic signed [SESSION_W-1:0] session_id;
    logic [INTERVAL_W-1:0]       interval_ms;

    modport source (
        output valid, req_type, now_ms, owner_handle, session_id, interval_ms,
        input  ready
    );
    modport sink (
        input  valid, req_type, now_ms, owner_handle, session_id, interval_ms,
        output ready
    );
endinterface

interface tmh_rsp_if import tmh_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic [HANDLE_W-1:0]         fired_handle;
    logic signed [SESSION_W-1:0] fired_session;
    logic [TIME_W-1:0]           timeout_ms;
    logic                        last_result;

    modport source (
        output valid, status, fired_handle, fired_session, timeout_ms, last_result,
        input  ready
    );
    modport sink (
        input  valid, status, fired_handle, fired_session, timeout_ms, last_result,
        output ready
    );
endinterface

// File: hdl/tmh_ram.sv
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/timer_min_heap_scheduler.sv
// register: a full heap answers full; else each later parent moves down into the hole
// until the new entry lands; query: reads the root, or answers empty on an empty heap
// tick: pops due roots up to the pop limit and sifts the tail entry down from the root;
// a fired word is sent once the next pop shows it was not final; a last word closes it
// one request at a time: the next is taken only back in idle, once the last word has
// moved to the output register; reset: async active low, no memory clear
module timer_min_heap_scheduler import tmh_pkg::*; #(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    tmh_req_if.sink  req,
    tmh_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    // child index 2i+1 needs one bit more than a heap index
    localparam int CH_W  = IDX_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_TK_TOP,
        S_TK_CHK,
        S_RM_KEY,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_Q_RD,
        S_Q_CMP,
        S_EMIT
    } state_t;

    state_t             state_reg;
    state_t             ret_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [POP_W-1:0]   pop_cnt_reg;
    logic [IDX_W-1:0]   pos_reg;       // insert hole or sift-down hole
    logic [IDX_W-1:0]   tail_reg;      // heap size after a pop
    logic               has_right_reg;
    entry_t             new_reg;       // entry being inserted, or sift-down key
    entry_t             left_reg;
    entry_t             hold_reg;      // last popped entry, waits to learn if final
    logic               hold_valid_reg;
    res_t               res_reg;       // pending result word
    res_t               out_reg;
    logic               out_valid_reg;

    // heap memory port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    entry_t             ram_rdata;

    // datapath helpers
    logic [TIME_W:0]    exp_sum;
    logic [TIME_W-1:0]  exp_sat;
    logic [IDX_W-1:0]   parent_idx;
    logic [CH_W-1:0]    child_w;
    logic               child_in;
    logic [IDX_W-1:0]   left_idx;
    logic [IDX_W-1:0]   right_idx;
    logic               pick_right;
    entry_t             pick;
    logic [IDX_W-1:0]   pick_idx;
    logic               ins_move;      // new entry passes its parent
    logic               dn_move;       // key yields to the smaller child
    logic               root_due;
    logic               tick_more;
    logic               out_free;
    logic               emit_fire;     // pending word moves into the output register
    res_t               finish_res;
    logic [TIME_W-1:0]  timeout_val;

    tmh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // expiry = last time + interval, saturated at the top of the time range
    assign exp_sum = {1'b0, last_time_reg} + (TIME_W + 1)'(req.interval_ms);
    assign exp_sat = exp_sum[TIME_W] ? '1 : exp_sum[TIME_W-1:0];

    assign parent_idx = IDX_W'((pos_reg - IDX_W'(1)) >> 1);
    assign child_w    = {pos_reg, 1'b1};
    assign child_in   = child_w < {1'b0, tail_reg};
    assign left_idx   = child_w[IDX_W-1:0];
    assign right_idx  = left_idx + IDX_W'(1);

    // right child only if the left one is strictly later
    assign pick_right = has_right_reg && (left_reg.expiry > ram_rdata.expiry);
    assign pick       = pick_right ? ram_rdata : left_reg;
    assign pick_idx   = pick_right ? right_idx : left_idx;

    // ties: insert stops at an equal parent, sift-down moves past an equal child
    assign ins_move = new_reg.expiry < ram_rdata.expiry;
    assign dn_move  = new_reg.expiry >= pick.expiry;

    assign root_due  = ram_rdata.expiry <= last_time_reg;
    assign tick_more = (count_reg != '0) && (pop_cnt_reg != POP_W'(MAX_POP));

    assign timeout_val = (ram_rdata.expiry > last_time_reg)
                       ? (ram_rdata.expiry - last_time_reg) : '0;

    // closing word of a tick: the held pop is final, or nothing was due
    assign finish_res = hold_valid_reg
                      ? make_res(ST_FIRED, hold_reg.owner, hold_reg.session, '0, 1'b1)
                      : make_res(ST_NONE, '0, '0, '0, 1'b1);

    assign out_free  = !out_valid_reg || rsp.ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;

    // memory control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = new_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            S_INS_CHK:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = parent_idx;
                end
            end
            S_INS_CMP:
            begin
                // parent moves down into the hole, or the new entry lands
                ram_we    = 1'b1;
                ram_wdata = ins_move ? ram_rdata : new_reg;
            end
            S_TK_TOP:
            begin
                ram_re = tick_more;
            end
            S_TK_CHK:
            begin
                // fetch the tail entry as the sift-down key
                ram_re    = root_due && (count_reg != CNT_W'(1));
                ram_raddr = IDX_W'(count_reg - CNT_W'(1));
            end
            S_DN_L:
            begin
                if (child_in)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = left_idx;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            S_DN_R:
            begin
                ram_re    = 1'b1;
                ram_raddr = right_idx;
            end
            S_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = dn_move ? pick : new_reg;
            end
            S_Q_RD:
            begin
                ram_re = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            count_reg      <= '0;
            last_time_reg  <= '0;
            pop_cnt_reg    <= '0;
            pos_reg        <= '0;
            tail_reg       <= '0;
            has_right_reg  <= 1'b0;
            new_reg        <= '0;
            left_reg       <= '0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            res_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // output word: loaded from the pending word, or dropped once taken
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        ret_reg <= S_IDLE;
                        case (req.req_type)
                            REQ_REGISTER:
                            begin
                                if (count_reg == CNT_W'(HEAP_DEPTH))
                                begin
                                    res_reg   <= make_res(ST_FULL, '0, '0, '0, 1'b1);
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    new_reg.expiry  <= exp_sat;
                                    new_reg.owner   <= req.owner_handle;
                                    new_reg.session <= req.session_id;
                                    pos_reg         <= IDX_W'(count_reg);
                                    state_reg       <= S_INS_CHK;
                                end
                            end
                            REQ_TICK:
                            begin
                                last_time_reg  <= req.now_ms;
                                pop_cnt_reg    <= '0;
                                hold_valid_reg <= 1'b0;
                                state_reg      <= S_TK_TOP;
                            end
                            REQ_QUERY:
                            begin
                                last_time_reg <= req.now_ms;
                                if (count_reg == '0)
                                begin
                                    res_reg   <= make_res(ST_EMPTY, '0, '0, '0, 1'b1);
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_Q_RD;
                                end
                            end
                            default:
                            begin
                                res_reg   <= make_res(ST_NONE, '0, '0, '0, 1'b1);
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end

                S_INS_CHK:
                begin
                    if (pos_reg == '0)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        res_reg   <= make_res(ST_REGISTERED, '0, '0, '0, 1'b1);
                        ret_reg   <= S_IDLE;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end

                S_INS_CMP:
                begin
                    if (ins_move)
                    begin
                        pos_reg   <= parent_idx;
                        state_reg <= S_INS_CHK;
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        res_reg   <= make_res(ST_REGISTERED, '0, '0, '0, 1'b1);
                        ret_reg   <= S_IDLE;
                        state_reg <= S_EMIT;
                    end
                end

                S_TK_TOP:
                begin
                    if (tick_more)
                    begin
                        state_reg <= S_TK_CHK;
                    end
                    else
                    begin
                        res_reg        <= finish_res;
                        hold_valid_reg <= 1'b0;
                        ret_reg        <= S_IDLE;
                        state_reg      <= S_EMIT;
                    end
                end

                S_TK_CHK:
                begin
                    if (root_due)
                    begin
                        // pop the root; the earlier pop is now known not final
                        hold_reg       <= ram_rdata;
                        hold_valid_reg <= 1'b1;
                        pop_cnt_reg    <= pop_cnt_reg + POP_W'(1);
                        count_reg      <= count_reg - CNT_W'(1);
                        tail_reg       <= IDX_W'(count_reg - CNT_W'(1));
                        if (hold_valid_reg)
                        begin
                            res_reg   <= make_res(ST_FIRED, hold_reg.owner,
                                                  hold_reg.session, '0, 1'b0);
                            ret_reg   <= (count_reg == CNT_W'(1)) ? S_TK_TOP : S_RM_KEY;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= (count_reg == CNT_W'(1)) ? S_TK_TOP : S_RM_KEY;
                        end
                    end
                    else
                    begin
                        res_reg        <= finish_res;
                        hold_valid_reg <= 1'b0;
                        ret_reg        <= S_IDLE;
                        state_reg      <= S_EMIT;
                    end
                end

                S_RM_KEY:
                begin
                    new_reg   <= ram_rdata;
                    pos_reg   <= '0;
                    state_reg <= S_DN_L;
                end

                S_DN_L:
                begin
                    state_reg <= child_in ? S_DN_R : S_TK_TOP;
                end

                S_DN_R:
                begin
                    left_reg      <= ram_rdata;
                    has_right_reg <= (child_w + CH_W'(1)) < {1'b0, tail_reg};
                    state_reg     <= S_DN_CMP;
                end

                S_DN_CMP:
                begin
                    if (dn_move)
                    begin
                        pos_reg   <= pick_idx;
                        state_reg <= S_DN_L;
                    end
                    else
                    begin
                        state_reg <= S_TK_TOP;
                    end
                end

                S_Q_RD:
                begin
                    state_reg <= S_Q_CMP;
                end

                S_Q_CMP:
                begin
                    res_reg   <= make_res(ST_TIMEOUT, '0, '0, timeout_val, 1'b1);
                    ret_reg   <= S_IDLE;
                    state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    // waits here while the output word is still held
                    if (out_free)
                    begin
                        out_reg   <= res_reg;
                        state_reg <= ret_reg;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a new word is taken whenever the sequencer is free, even with a result pending
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.fired_handle  = out_reg.handle;
    assign rsp.fired_session = out_reg.session;
    assign rsp.timeout_ms    = out_reg.timeout;
    assign rsp.last_result   = out_reg.last;

endmodule

// File: hdl/tmh_checker.sv
module tmh_checker import tmh_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic                last_result
);

    // a held result word does not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(last_result))
        else $error("result word changed while stalled");

    // only defined status codes come out
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_EMPTY))
        else $error("undefined status code");

    // every result but a fired timer closes its request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_FIRED) |-> last_result)
        else $error("non-fired result not marked last");

    // an accepted request drops ready while the block works on it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one still in work");

endmodule

bind timer_min_heap_scheduler tmh_checker u_tmh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .last_result (rsp.last_result)
);
